>>> hw/rtl/ues_pkg.sv
// Shared types and constants for the URL encoder and splitter.
// Used by ues_front, ues_back and url_encode_and_split; depends on nothing.
package ues_pkg;

  // Depth of the character queue between the front and the back
  localparam int QUEUE_DEPTH = 4;

  // Reset values of the default port registers
  localparam logic [15:0] HTTP_PORT_RST  = 16'd80;
  localparam logic [15:0] HTTPS_PORT_RST = 16'd443;

  // Register indexes on the configuration port
  localparam logic CFG_HTTP_PORT  = 1'b0;
  localparam logic CFG_HTTPS_PORT = 1'b1;

  // One encoded input byte: either a plain character or a %XX escape
  typedef struct packed {
    logic       is_pct;  // raw byte >= 0x80, expands to three characters
    logic [7:0] ch;      // plain character, or the raw byte for an escape
    logic       last;    // final byte of the URL
  } chr_entry_t;

  typedef struct packed {
    logic [15:0] http;
    logic [15:0] https;
  } dflt_ports_t;

endpackage

>>> hw/rtl/ues_front.sv
// Front end: encodes raw URL bytes (whitespace to '+', high bytes flagged
// for %XX) and queues them for the back end. Depends on ues_pkg.
module ues_front #(
  parameter int DEPTH = ues_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,   // [7:0] in_byte
  input  logic                in_tlast,
  output logic                head_valid,
  output ues_pkg::chr_entry_t head,
  input  logic                pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ues_pkg::chr_entry_t mem_r [DEPTH];
  logic [PW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  ues_pkg::chr_entry_t enc;
  logic                is_ws;
  logic                push;

  assign is_ws = (in_tdata == 8'h20) || (in_tdata >= 8'h09 && in_tdata <= 8'h0D);

  always_comb begin
    enc.is_pct = in_tdata[7];
    enc.ch     = is_ws ? 8'h2B : in_tdata;
    enc.last   = in_tlast;
  end

  assign in_tready  = (cnt_r != CW'(DEPTH));
  assign push       = in_tvalid && in_tready;
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= enc;
    end
  end

endmodule

>>> hw/rtl/ues_back.sv
// Back end: walks the queued characters through the scheme/host/port/path/query parser
// and drives at most one result per cycle, stalling on out_tready. Depends on ues_pkg.
module ues_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 head_valid,
  input  ues_pkg::chr_entry_t  head,
  output logic                 pop,
  input  ues_pkg::dflt_ports_t ports,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          out_tdata,  // [7:0] out_byte, [10:8] status, [27:11] port
  output logic [3:0]           out_tuser,  // [0] has_byte, [3:1] field
  output logic                 out_tlast
);

  typedef enum logic [2:0] {
    M_SCHEME = 3'd0,
    M_HOST   = 3'd1,
    M_PORT   = 3'd2,
    M_PATH   = 3'd3,
    M_QUERY  = 3'd4
  } mode_t;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_SEP   = 3'd1;
  localparam logic [2:0] ST_NO_SLASH = 3'd2;
  localparam logic [2:0] ST_COLONS   = 3'd3;
  localparam logic [2:0] ST_BAD_PORT = 3'd4;

  // http/https prefix tracker
  localparam logic [2:0] SCM_START = 3'd0;
  localparam logic [2:0] SCM_H     = 3'd1;
  localparam logic [2:0] SCM_HT    = 3'd2;
  localparam logic [2:0] SCM_HTT   = 3'd3;
  localparam logic [2:0] SCM_HTTP  = 3'd4;
  localparam logic [2:0] SCM_HTTPS = 3'd5;
  localparam logic [2:0] SCM_FAIL  = 3'd6;

  // held separator: nothing, ':', ":/", or only '/' left to release
  localparam logic [1:0] SEP_NONE  = 2'd0;
  localparam logic [1:0] SEP_COLON = 2'd1;
  localparam logic [1:0] SEP_CS    = 2'd2;
  localparam logic [1:0] SEP_SLASH = 2'd3;

  localparam logic [1:0] SGN_NONE = 2'd0;
  localparam logic [1:0] SGN_POS  = 2'd1;
  localparam logic [1:0] SGN_NEG  = 2'd2;

  localparam logic [7:0] CH_COLON = ":";
  localparam logic [7:0] CH_SLASH = "/";
  localparam logic [7:0] CH_QUEST = "?";
  localparam logic [7:0] CH_PCT   = "%";
  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_0     = "0";
  localparam logic [7:0] CH_9     = "9";
  localparam logic [7:0] CH_H     = "h";
  localparam logic [7:0] CH_T     = "t";
  localparam logic [7:0] CH_P     = "p";
  localparam logic [7:0] CH_S     = "s";

  localparam logic [16:0] PORT_NONE = '1;
  localparam logic [16:0] PORT_MAXV = 17'd65535;
  localparam logic [20:0] PORT_CAP  = 21'd65536;

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    logic [7:0] d;
    begin
      if (n < 4'd10) begin
        d = CH_0 + 8'(n);
      end else begin
        d = 8'h41 + 8'(n - 4'd10);
      end
      return d;
    end
  endfunction

  function automatic logic [2:0] scm_step(input logic [2:0] s, input logic [7:0] c);
    logic [2:0] n;
    begin
      n = SCM_FAIL;
      if (s == SCM_START && c == CH_H) begin
        n = SCM_H;
      end else if ((s == SCM_H || s == SCM_HT) && c == CH_T) begin
        n = s + 3'd1;
      end else if (s == SCM_HTT && c == CH_P) begin
        n = SCM_HTTP;
      end else if (s == SCM_HTTP && c == CH_S) begin
        n = SCM_HTTPS;
      end
      return n;
    end
  endfunction

  mode_t       mode_r, mode_nxt;
  logic [1:0]  sep_r, sep_nxt;
  logic [2:0]  scm_r, scm_nxt;
  logic [1:0]  colons_r, colons_nxt;
  logic [16:0] pval_r, pval_nxt;
  logic [1:0]  psign_r, psign_nxt;
  logic        pend_r, pend_nxt;
  logic [2:0]  err_r, err_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic        closing_r, closing_nxt;
  logic        sep_item_r, sep_item_nxt;   // "://" completed within the current byte
  logic        ov_r, ov_nxt;
  logic        o_hb_r, o_hb_nxt;
  logic [7:0]  o_byte_r, o_byte_nxt;
  logic [2:0]  o_field_r, o_field_nxt;
  logic [2:0]  o_status_r, o_status_nxt;
  logic [16:0] o_port_r, o_port_nxt;
  logic        o_last_r, o_last_nxt;

  logic [7:0]  cur_ch;
  logic        at_end;
  logic        go;
  logic        consume;
  logic        is_digit;
  logic        port_bad;
  logic [20:0] prod;
  logic [16:0] fin_port;

  always_comb begin
    if (!head.is_pct) begin
      cur_ch = head.ch;
    end else if (idx_r == 2'd0) begin
      cur_ch = CH_PCT;
    end else if (idx_r == 2'd1) begin
      cur_ch = hex_digit(head.ch[7:4]);
    end else begin
      cur_ch = hex_digit(head.ch[3:0]);
    end
  end

  assign at_end   = head.is_pct ? (idx_r == 2'd2) : 1'b1;
  assign go       = head_valid && (!ov_r || out_tready);
  assign is_digit = (cur_ch >= CH_0) && (cur_ch <= CH_9);
  assign port_bad = pval_r[16] || (psign_r == SGN_NEG && pval_r != '0);
  assign prod     = 21'({pval_r, 3'b000}) + 21'({pval_r, 1'b0}) + 21'(cur_ch[3:0]);

  always_comb begin
    if (err_r == ST_COLONS) begin
      fin_port = PORT_NONE;
    end else if (err_r == ST_BAD_PORT) begin
      fin_port = pval_r[16] ? PORT_MAXV : PORT_NONE;
    end else if (colons_r == 2'd1) begin
      fin_port = (psign_r == SGN_NEG) ? '0 : pval_r;
    end else if (scm_r == SCM_HTTP) begin
      fin_port = {1'b0, ports.http};
    end else if (scm_r == SCM_HTTPS) begin
      fin_port = {1'b0, ports.https};
    end else begin
      fin_port = PORT_NONE;
    end
  end

  always_comb begin
    mode_nxt     = mode_r;
    sep_nxt      = sep_r;
    scm_nxt      = scm_r;
    colons_nxt   = colons_r;
    pval_nxt     = pval_r;
    psign_nxt    = psign_r;
    pend_nxt     = pend_r;
    err_nxt      = err_r;
    idx_nxt      = idx_r;
    closing_nxt  = closing_r;
    sep_item_nxt = sep_item_r;
    ov_nxt       = ov_r && !out_tready;
    o_hb_nxt     = o_hb_r;
    o_byte_nxt   = o_byte_r;
    o_field_nxt  = o_field_r;
    o_status_nxt = o_status_r;
    o_port_nxt   = o_port_r;
    o_last_nxt   = o_last_r;
    pop          = 1'b0;
    consume      = 1'b0;

    if (go && closing_r) begin
      if (mode_r == M_SCHEME && sep_r != SEP_NONE) begin
        // flush held separator characters as scheme text
        ov_nxt       = 1'b1;
        o_hb_nxt     = 1'b1;
        o_field_nxt  = 3'(M_SCHEME);
        o_status_nxt = ST_OK;
        o_port_nxt   = '0;
        o_last_nxt   = 1'b0;
        if (sep_r == SEP_SLASH) begin
          o_byte_nxt = CH_SLASH;
          scm_nxt    = scm_step(scm_r, CH_SLASH);
          sep_nxt    = SEP_NONE;
        end else begin
          o_byte_nxt = CH_COLON;
          scm_nxt    = scm_step(scm_r, CH_COLON);
          sep_nxt    = (sep_r == SEP_CS) ? SEP_SLASH : SEP_NONE;
        end
      end else begin
        ov_nxt      = 1'b1;
        o_hb_nxt    = 1'b0;
        o_byte_nxt  = '0;
        o_field_nxt = '0;
        o_last_nxt  = 1'b1;
        case (mode_r)
          M_SCHEME: begin
            o_status_nxt = ST_NO_SEP;
            o_port_nxt   = PORT_NONE;
          end
          M_HOST, M_PORT: begin
            o_status_nxt = sep_item_r ? ST_OK : ST_NO_SLASH;
            o_port_nxt   = PORT_NONE;
          end
          default: begin
            o_status_nxt = err_r;
            o_port_nxt   = fin_port;
          end
        endcase
        pop          = 1'b1;
        mode_nxt     = M_SCHEME;
        sep_nxt      = SEP_NONE;
        scm_nxt      = SCM_START;
        colons_nxt   = '0;
        pval_nxt     = '0;
        psign_nxt    = SGN_NONE;
        pend_nxt     = 1'b0;
        err_nxt      = ST_OK;
        idx_nxt      = '0;
        closing_nxt  = 1'b0;
        sep_item_nxt = 1'b0;
      end
    end else if (go) begin
      o_hb_nxt     = 1'b1;
      o_byte_nxt   = cur_ch;
      o_field_nxt  = 3'(mode_r);
      o_status_nxt = ST_OK;
      o_port_nxt   = '0;
      o_last_nxt   = 1'b0;
      case (mode_r)
        M_SCHEME: begin
          if (sep_r == SEP_SLASH) begin
            ov_nxt     = 1'b1;
            o_byte_nxt = CH_SLASH;
            scm_nxt    = scm_step(scm_r, CH_SLASH);
            sep_nxt    = SEP_NONE;
          end else if (cur_ch == CH_SLASH && sep_r == SEP_COLON) begin
            sep_nxt = SEP_CS;
            consume = 1'b1;
          end else if (cur_ch == CH_SLASH && sep_r == SEP_CS) begin
            sep_nxt      = SEP_NONE;
            mode_nxt     = M_HOST;
            sep_item_nxt = 1'b1;
            consume      = 1'b1;
          end else if (sep_r != SEP_NONE) begin
            // release a held ':' first; a held ':' before another ':' stays held
            ov_nxt     = 1'b1;
            o_byte_nxt = CH_COLON;
            scm_nxt    = scm_step(scm_r, CH_COLON);
            if (sep_r == SEP_CS) begin
              sep_nxt = SEP_SLASH;
            end else if (cur_ch == CH_COLON) begin
              consume = 1'b1;
            end else begin
              sep_nxt = SEP_NONE;
            end
          end else if (cur_ch == CH_COLON) begin
            sep_nxt = SEP_COLON;
            consume = 1'b1;
          end else begin
            ov_nxt  = 1'b1;
            scm_nxt = scm_step(scm_r, cur_ch);
            consume = 1'b1;
          end
        end
        M_HOST, M_PORT: begin
          consume = 1'b1;
          if (cur_ch == CH_COLON) begin
            if (colons_r < 2'd2) begin
              colons_nxt = colons_r + 2'd1;
            end
            mode_nxt = M_PORT;
          end else if (cur_ch == CH_SLASH) begin
            if (colons_r >= 2'd2) begin
              err_nxt = ST_COLONS;
            end else if (colons_r == 2'd1 && port_bad) begin
              err_nxt = ST_BAD_PORT;
            end else begin
              err_nxt = ST_OK;
            end
            mode_nxt    = M_PATH;
            ov_nxt      = 1'b1;
            o_field_nxt = 3'(M_PATH);
          end else begin
            ov_nxt = 1'b1;
            if (mode_r == M_PORT && !pend_r) begin
              if (psign_r == SGN_NONE && cur_ch == CH_PLUS) begin
                psign_nxt = SGN_POS;
              end else if (psign_r == SGN_NONE && cur_ch == CH_MINUS) begin
                psign_nxt = SGN_NEG;
              end else if (!is_digit) begin
                pend_nxt = 1'b1;
              end else begin
                if (psign_r == SGN_NONE) begin
                  psign_nxt = SGN_POS;
                end
                pval_nxt = (prod > PORT_CAP) ? PORT_CAP[16:0] : prod[16:0];
              end
            end
          end
        end
        M_PATH: begin
          consume = 1'b1;
          if (cur_ch == CH_QUEST) begin
            mode_nxt = M_QUERY;
          end else begin
            ov_nxt = 1'b1;
          end
        end
        default: begin
          consume = 1'b1;
          ov_nxt  = 1'b1;
        end
      endcase

      if (consume) begin
        if (!at_end) begin
          idx_nxt = idx_r + 2'd1;
        end else if (head.last) begin
          closing_nxt = 1'b1;
        end else begin
          pop          = 1'b1;
          idx_nxt      = '0;
          sep_item_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= M_SCHEME;
      sep_r      <= SEP_NONE;
      scm_r      <= SCM_START;
      colons_r   <= '0;
      pval_r     <= '0;
      psign_r    <= SGN_NONE;
      pend_r     <= 1'b0;
      err_r      <= ST_OK;
      idx_r      <= '0;
      closing_r  <= 1'b0;
      sep_item_r <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      mode_r     <= mode_nxt;
      sep_r      <= sep_nxt;
      scm_r      <= scm_nxt;
      colons_r   <= colons_nxt;
      pval_r     <= pval_nxt;
      psign_r    <= psign_nxt;
      pend_r     <= pend_nxt;
      err_r      <= err_nxt;
      idx_r      <= idx_nxt;
      closing_r  <= closing_nxt;
      sep_item_r <= sep_item_nxt;
      ov_r       <= ov_nxt;
    end
    o_hb_r     <= o_hb_nxt;
    o_byte_r   <= o_byte_nxt;
    o_field_r  <= o_field_nxt;
    o_status_r <= o_status_nxt;
    o_port_r   <= o_port_nxt;
    o_last_r   <= o_last_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {4'b0000, o_port_r, o_status_r, o_byte_r};
  assign out_tuser  = {o_field_r, o_hb_r};
  assign out_tlast  = o_last_r;

endmodule

>>> hw/rtl/url_encode_and_split.sv
// URL encoder and splitter: takes one raw URL byte per request and returns the
// encoded characters tagged scheme/host/port/path/query, then a closing request
// with status and port at the end of each URL. The back end drives at most one
// result per cycle while out_tready allows; a byte of 0x80 and above expands to
// three characters (%XX). A held ':' or ":/", the "://" slashes, host colons and
// the query '?' give no result. A held separator character that turns out to be
// scheme text is released as a scheme result, whether by the next scheme character
// or at the end of the URL, and the end of a URL adds the closing item.
// A QUEUE_DEPTH-entry queue between the encoder and the parser absorbs the
// expansion; input is taken whenever the queue has room, and the output
// register is refilled in the cycle it drains.
// Depends on ues_pkg, ues_front and ues_back.
module url_encode_and_split #(
  parameter int QUEUE_DEPTH = ues_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,   // in_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] out_byte, [10:8] status, [27:11] port
  output logic [3:0]  out_tuser,  // [0] has_byte, [3:1] field
  output logic        out_tlast,  // last
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic [15:0]          http_port_r, http_port_nxt;
  logic [15:0]          https_port_r, https_port_nxt;
  ues_pkg::dflt_ports_t ports;
  ues_pkg::chr_entry_t  head;
  logic                 head_valid;
  logic                 pop;

  always_comb begin
    http_port_nxt  = http_port_r;
    https_port_nxt = https_port_r;
    if (cfg_we) begin
      case (cfg_index)
        ues_pkg::CFG_HTTP_PORT:  http_port_nxt  = cfg_wdata;
        ues_pkg::CFG_HTTPS_PORT: https_port_nxt = cfg_wdata;
        default: begin
          http_port_nxt = http_port_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      http_port_r  <= ues_pkg::HTTP_PORT_RST;
      https_port_r <= ues_pkg::HTTPS_PORT_RST;
    end else begin
      http_port_r  <= http_port_nxt;
      https_port_r <= https_port_nxt;
    end
  end

  assign ports.http  = http_port_r;
  assign ports.https = https_port_r;

  ues_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  ues_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .ports      (ports),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
